// ----- rtl/core/wgb_pkg.sv -----
// Shared types, constants and codes for the write gather burst pipe.
package wgb_pkg;

  localparam int GATHER_BYTES_DEF = 32;
  localparam int BEAT_BYTES       = 8;
  localparam int MAX_STORE        = 4;
  localparam int QUEUE_DEPTH      = 2;

  localparam int REG_W      = 32;
  localparam int RAM_W      = 30;
  localparam int PHYS_W     = 29;
  localparam int SIZE_W     = 4;
  localparam int BEAT_IDX_W = 2;
  localparam int CFG_IDX_W  = 2;
  // range check needs room for phys address plus a full stage
  localparam int RNG_W      = 31;

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_DROP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIFO_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIFO_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BYTES   = 2'd3;

  typedef struct packed {
    logic [PHYS_W-1:0] addr;
    logic              in_range;
  } burst_meta_t;

endpackage

// ----- rtl/core/wgb_front.sv -----
// Front end: config registers, byte gather stage, write pointer and burst request.
module wgb_front import wgb_pkg::*; #(
  parameter int GATHER_BYTES = GATHER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  input  logic                     in_fire,
  input  logic                     cmd,
  input  logic [REG_W-1:0]         store_value,
  input  logic [SIZE_W-1:0]        store_size,
  output logic                     burst_push,
  output logic [GATHER_BYTES*8-1:0] burst_data,
  output burst_meta_t              burst_meta
);

  localparam int CW = $clog2(GATHER_BYTES);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] G_S = SW'(GATHER_BYTES);

  logic [REG_W-1:0] fifo_base;
  logic [REG_W-1:0] fifo_end;
  logic [RAM_W-1:0] ram_bytes;
  logic [REG_W-1:0] wp;
  logic [CW-1:0]    staged_count;
  logic [7:0]       stage [GATHER_BYTES];

  logic [2:0]       size_c;
  logic             is_store;
  logic             bval  [MAX_STORE];
  logic [7:0]       bbyte [MAX_STORE];
  logic [1:0]       bsh   [MAX_STORE];
  logic [SW-1:0]    bpos  [MAX_STORE];
  logic             bwrap [MAX_STORE];
  logic [CW-1:0]    bidx  [MAX_STORE];
  logic [SW-1:0]    total;
  logic             fill;
  logic [CW-1:0]    staged_count_next;
  logic [7:0]       fill_stage [GATHER_BYTES];
  logic [7:0]       stage_next [GATHER_BYTES];
  logic [REG_W-1:0] wp_next;

  always_comb begin
    size_c = (store_size > SIZE_W'(MAX_STORE)) ? 3'(MAX_STORE) : store_size[2:0];
    is_store = in_fire && (cmd == CMD_STORE);
    for (int i = 0; i < MAX_STORE; i++) begin
      // appended bytes come out big-endian from the low size_c bytes
      bsh[i]   = 2'(size_c - 3'd1 - 3'(i));
      bbyte[i] = 8'(store_value >> {bsh[i], 3'b000});
      bval[i]  = is_store && (3'(i) < size_c);
      bpos[i]  = SW'(staged_count) + SW'(i);
      bwrap[i] = bpos[i] >= G_S;
      bidx[i]  = bwrap[i] ? CW'(bpos[i] - G_S) : CW'(bpos[i]);
    end
    total = SW'(staged_count) + SW'(size_c);
    fill  = is_store && (total >= G_S);
    staged_count_next = fill ? CW'(total - G_S) : CW'(total);
  end

  // burst snapshot takes only bytes landing before the wrap
  always_comb begin
    for (int k = 0; k < GATHER_BYTES; k++) begin
      fill_stage[k] = stage[k];
      for (int i = 0; i < MAX_STORE; i++) begin
        if (bval[i] && !bwrap[i] && (bidx[i] == CW'(k))) begin
          fill_stage[k] = bbyte[i];
        end
      end
      stage_next[k] = fill_stage[k];
      for (int i = 0; i < MAX_STORE; i++) begin
        if (bval[i] && bwrap[i] && (bidx[i] == CW'(k))) begin
          stage_next[k] = bbyte[i];
        end
      end
      burst_data[8*(GATHER_BYTES-1-k) +: 8] = fill_stage[k];
    end
  end

  assign burst_push          = fill;
  assign burst_meta.addr     = wp[PHYS_W-1:0];
  assign burst_meta.in_range =
    (RNG_W'(wp[PHYS_W-1:0]) + RNG_W'(GATHER_BYTES)) <= RNG_W'(ram_bytes);
  assign wp_next = (wp == fifo_end) ? fifo_base : wp + REG_W'(GATHER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_base    <= '0;
      fifo_end     <= '0;
      ram_bytes    <= '0;
      wp           <= '0;
      staged_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIFO_BASE:   fifo_base <= cfg_data;
          REG_FIFO_END:    fifo_end  <= cfg_data;
          REG_WRITE_START: wp        <= cfg_data;
          REG_RAM_BYTES:   ram_bytes <= cfg_data[RAM_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (cmd == CMD_DROP) begin
          staged_count <= '0;
        end else begin
          staged_count <= staged_count_next;
        end
      end
      if (fill) begin
        wp <= wp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_store) begin
      stage <= stage_next;
    end
  end

  a_drop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == CMD_DROP)) |=> (staged_count == '0))
    else $error("drop did not clear staged count");

  a_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    fill |=> (wp == $past(wp_next)))
    else $error("write pointer did not advance after burst");

endmodule

// ----- rtl/core/wgb_queue.sv -----
// Short burst queue between the gather front end and the beat sequencer.
module wgb_queue import wgb_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         nonempty,
  output logic         full
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("burst queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("burst queue count out of bounds");

endmodule

// ----- rtl/core/wgb_back.sv -----
// Back end: walks the head burst beat by beat into the output register.
module wgb_back import wgb_pkg::*; #(
  parameter int GATHER_BYTES = GATHER_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [GATHER_BYTES*8-1:0] q_data,
  input  burst_meta_t               q_meta,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [BEAT_BYTES*8-1:0]   beat_data,
  output logic [BEAT_IDX_W-1:0]     beat_index,
  output logic [PHYS_W-1:0]         burst_address,
  output logic                      in_range,
  output logic                      last_beat
);

  localparam int NBEATS = GATHER_BYTES / BEAT_BYTES;
  localparam int BW     = (NBEATS > 1) ? $clog2(NBEATS) : 1;
  localparam int BEAT_W = BEAT_BYTES * 8;

  logic [BEAT_W-1:0] beat_arr [NBEATS];
  logic [BW-1:0]     beat_cnt;
  logic              out_valid;
  logic              cnt_last;
  logic              load;

  always_comb begin
    for (int b = 0; b < NBEATS; b++) begin
      beat_arr[b] = q_data[GATHER_BYTES*8-1-BEAT_W*b -: BEAT_W];
    end
  end

  assign cnt_last = (beat_cnt == BW'(NBEATS - 1));
  assign load     = q_valid && (!out_valid || pop);
  assign q_pop    = load && cnt_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_cnt  <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_cnt  <= cnt_last ? '0 : beat_cnt + BW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_data     <= beat_arr[beat_cnt];
      beat_index    <= BEAT_IDX_W'(beat_cnt);
      burst_address <= q_meta.addr;
      in_range      <= q_meta.in_range;
      last_beat     <= cnt_last;
    end
  end

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (beat_cnt == '0) && out_valid && last_beat)
    else $error("burst released before its final beat");

endmodule

// ----- rtl/core/write_gather_burst_pipe_core.sv -----
// Flow: a store that fills the stage is pushed into the burst queue, then loaded into the beat
// register and put on the result ports; that load waits while an unpopped beat is held there.
// Beats then leave one per cycle while pop is held; a burst of GATHER_BYTES/8 beats drains
// from a 2-entry queue. Commands are taken one per cycle while full is low; push stalls (full)
// only while the burst queue is full, which the beat sequencer drains as each final beat loads.
// Reset (rst, synchronous): registers, write pointer and staged count clear; stage bytes do not.
module write_gather_burst_pipe_core import wgb_pkg::*; #(
  parameter int GATHER_BYTES = GATHER_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic                    cmd,
  input  logic [REG_W-1:0]        store_value,
  input  logic [SIZE_W-1:0]       store_size,
  output logic                    empty,
  input  logic                    pop,
  output logic [BEAT_BYTES*8-1:0] beat_data,
  output logic [BEAT_IDX_W-1:0]   beat_index,
  output logic [PHYS_W-1:0]       burst_address,
  output logic                    in_range,
  output logic                    last_beat
);

  localparam int DW = GATHER_BYTES * 8;
  localparam int QW = DW + $bits(burst_meta_t);

  logic              in_fire;
  logic              burst_push;
  logic [DW-1:0]     burst_data;
  burst_meta_t       burst_meta;
  logic [QW-1:0]     q_head;
  logic              q_valid;
  logic              q_pop;
  logic [DW-1:0]     q_data;
  burst_meta_t       q_meta;

  assign in_fire = push && !full;
  assign q_data  = q_head[QW-1 -: DW];
  assign q_meta  = q_head[$bits(burst_meta_t)-1:0];

  wgb_front #(.GATHER_BYTES(GATHER_BYTES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .cmd         (cmd),
    .store_value (store_value),
    .store_size  (store_size),
    .burst_push  (burst_push),
    .burst_data  (burst_data),
    .burst_meta  (burst_meta)
  );

  wgb_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (burst_push),
    .push_data ({burst_data, burst_meta}),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_valid),
    .full      (full)
  );

  wgb_back #(.GATHER_BYTES(GATHER_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_data        (q_data),
    .q_meta        (q_meta),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .beat_data     (beat_data),
    .beat_index    (beat_index),
    .burst_address (burst_address),
    .in_range      (in_range),
    .last_beat     (last_beat)
  );

endmodule
